FILE: sv/jac_pkg.sv
`default_nettype none

package jac_pkg;

	// sample group shape
	localparam int SAMPLE_COUNT = 5;
	localparam int FIELD_SAMPLES = 5;
	localparam int NSAMP = (SAMPLE_COUNT > FIELD_SAMPLES) ? FIELD_SAMPLES :
		((SAMPLE_COUNT < 1) ? 1 : SAMPLE_COUNT);
	localparam int MED_IDX = NSAMP / 2;
	localparam int RANK_W = (NSAMP > 1) ? $clog2(NSAMP) : 1;

	// field widths
	localparam int RAW_W = 10;
	localparam int DROP_BITS = 2;
	localparam int SMP_W = RAW_W - DROP_BITS;
	localparam int TRIM_W = 8;
	localparam int AXIS_W = 10;
	localparam int CALC_W = AXIS_W + 1;
	localparam int CFG_W = 10;
	localparam int IDX_W = 2;

	// arithmetic constants
	localparam logic signed [CALC_W-1:0] MIDPOINT = CALC_W'(128);
	localparam logic signed [CALC_W-1:0] DEADZONE = CALC_W'(4);

	// register reset values
	localparam logic signed [TRIM_W-1:0] TRIM_RST = '0;
	localparam logic signed [AXIS_W-1:0] LOW_RST = -AXIS_W'(256);
	localparam logic signed [AXIS_W-1:0] HIGH_RST = AXIS_W'(256);
	localparam logic signed [AXIS_W-1:0] LAST_RST = -AXIS_W'(1);

	typedef logic [SMP_W-1:0] smp_t;
	typedef smp_t [NSAMP-1:0] smp_vec_t;

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_CENTER_TRIM = 2'd0,
		REG_INVERT_AXIS = 2'd1,
		REG_CLAMP_LOW   = 2'd2,
		REG_CLAMP_HIGH  = 2'd3
	} cfg_reg_t;

	// median by stable rank: exactly one element sits at the middle rank
	function automatic smp_t median_sel(input smp_vec_t v);
		logic [RANK_W-1:0] rank;
		smp_t med;
		med = '0;
		for (int i = 0; i < NSAMP; i++) begin
			rank = '0;
			for (int j = 0; j < NSAMP; j++) begin
				if (j != i) begin
					if ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i))) begin
						rank = rank + RANK_W'(1);
					end
				end
			end
			if (rank == RANK_W'(MED_IDX)) begin
				med = v[i];
			end
		end
		return med;
	endfunction

endpackage

`default_nettype wire

FILE: sv/joystick_axis_conditioner_top.sv
// path: input register, then result register; throughput: one word per
// cycle unless out_ready stalls; the axis state updates in the same cycle
// that a word leaves the input register, so words may follow back to back
// reset: arst_n clears all control state, the registers to their defaults
// and the stored axis value to minus one
`default_nettype none

module joystick_axis_conditioner_top
	import jac_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// configuration
	input  wire logic                     cfg_we,
	input  wire logic [IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_W-1:0]         cfg_data,
	// input words
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [RAW_W-1:0]         sample_a,
	input  wire logic [RAW_W-1:0]         sample_b,
	input  wire logic [RAW_W-1:0]         sample_c,
	input  wire logic [RAW_W-1:0]         sample_d,
	input  wire logic [RAW_W-1:0]         sample_e,
	input  wire logic                     ack_consumed,
	// result words
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [AXIS_W-1:0]      axis_value,
	output logic                          value_changed,
	output logic                          value_ready
);

	logic signed [TRIM_W-1:0] center_trim_q;
	logic                     invert_axis_q;
	logic signed [AXIS_W-1:0] clamp_low_q;
	logic signed [AXIS_W-1:0] clamp_high_q;

	logic signed [AXIS_W-1:0] last_q;
	logic                     changed_q;
	logic                     ready_q;

	logic                     valid_s1;
	smp_vec_t                 smp_s1;
	logic                     ack_s1;

	logic                     advance;
	logic                     in_take;
	smp_vec_t                 smp_in;
	logic [RAW_W-1:0]         raw [FIELD_SAMPLES];

	smp_t                     med;
	logic signed [CALC_W-1:0] trimmed;
	logic signed [CALC_W-1:0] signed_val;
	logic signed [CALC_W-1:0] low_ext;
	logic signed [CALC_W-1:0] high_ext;
	logic signed [CALC_W-1:0] lo_clamped;
	logic signed [CALC_W-1:0] hi_clamped;
	logic signed [AXIS_W-1:0] new_val;
	logic                     pend_eff;

	// handshake
	assign advance  = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	// cut the raw readings to 8 bits
	assign raw[0] = sample_a;
	assign raw[1] = sample_b;
	assign raw[2] = sample_c;
	assign raw[3] = sample_d;
	assign raw[4] = sample_e;

	always_comb begin
		for (int k = 0; k < NSAMP; k++) begin
			smp_in[k] = raw[k][RAW_W-1:DROP_BITS];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_trim_q <= TRIM_RST;
			invert_axis_q <= 1'b0;
			clamp_low_q   <= LOW_RST;
			clamp_high_q  <= HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER_TRIM: center_trim_q <= cfg_data[TRIM_W-1:0];
				REG_INVERT_AXIS: invert_axis_q <= cfg_data[0];
				REG_CLAMP_LOW:   clamp_low_q   <= cfg_data[AXIS_W-1:0];
				REG_CLAMP_HIGH:  clamp_high_q  <= cfg_data[AXIS_W-1:0];
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			smp_s1 <= smp_in;
			ack_s1 <= ack_consumed;
		end
	end

	// median, trim, invert, clamp, deadzone
	always_comb begin
		med        = median_sel(smp_s1);
		trimmed    = $signed({3'b000, med}) - MIDPOINT + CALC_W'(center_trim_q);
		signed_val = invert_axis_q ? -trimmed : trimmed;
		low_ext    = CALC_W'(clamp_low_q);
		high_ext   = CALC_W'(clamp_high_q);
		lo_clamped = (signed_val < low_ext) ? low_ext : signed_val;
		hi_clamped = (lo_clamped > high_ext) ? high_ext : lo_clamped;
		if ((hi_clamped > -DEADZONE) && (hi_clamped < DEADZONE)) begin
			new_val = '0;
		end else begin
			new_val = hi_clamped[AXIS_W-1:0];
		end
		pend_eff = ready_q && !ack_s1;
	end

	// axis state, updated as the word moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= LAST_RST;
			changed_q <= 1'b0;
			ready_q   <= 1'b0;
		end else if (valid_s1 && advance) begin
			ready_q <= pend_eff;
			if (!pend_eff) begin
				if (new_val == last_q) begin
					changed_q <= 1'b0;
				end else begin
					last_q    <= new_val;
					changed_q <= 1'b1;
					ready_q   <= 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	assign axis_value    = last_q;
	assign value_changed = changed_q;
	assign value_ready   = ready_q;

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import jac_pkg::*;

	localparam int MID_CODE = 128;
	localparam int DEAD_BAND = 4;

	typedef logic [FIELD_SAMPLES-1:0][RAW_W-1:0] raw_group_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] axis;
		logic                     changed;
		logic                     ready;
	} axis_word_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [IDX_W-1:0]         cfg_index;
	logic [CFG_W-1:0]         cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic [RAW_W-1:0]         sample_a;
	logic [RAW_W-1:0]         sample_b;
	logic [RAW_W-1:0]         sample_c;
	logic [RAW_W-1:0]         sample_d;
	logic [RAW_W-1:0]         sample_e;
	logic                     ack_consumed;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [AXIS_W-1:0] axis_value;
	logic                     value_changed;
	logic                     value_ready;

	// mirror of the register file
	int   trim_m;
	logic invert_m;
	int   low_m;
	int   high_m;

	// mirror of the axis state
	int   last_axis_m;
	logic changed_m;
	logic pending_m;

	axis_word_t expected_axis_q[$];
	raw_group_t last_group;
	int         errors;
	bit         calm_mode;
	int         rx_hold;

	joystick_axis_conditioner_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_a      (sample_a),
		.sample_b      (sample_b),
		.sample_c      (sample_c),
		.sample_d      (sample_d),
		.sample_e      (sample_e),
		.ack_consumed  (ack_consumed),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.axis_value    (axis_value),
		.value_changed (value_changed),
		.value_ready   (value_ready)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// run limit
	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (calm_mode) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// median, trim, invert, clamp and deadzone of one sample group
	function automatic int conditioned_axis(input raw_group_t grp);
		int v[FIELD_SAMPLES];
		int key;
		int i;
		int j;
		int r;
		for (i = 0; i < NSAMP; i++) begin
			v[i] = int'(grp[i][RAW_W-1:DROP_BITS]);
		end
		for (i = 1; i < NSAMP; i++) begin
			key = v[i];
			j = i - 1;
			while (j >= 0 && v[j] > key) begin
				v[j + 1] = v[j];
				j--;
			end
			v[j + 1] = key;
		end
		r = v[MED_IDX] - MID_CODE + trim_m;
		if (invert_m) r = -r;
		if (r < low_m) r = low_m;
		if (r > high_m) r = high_m;
		if (r > -DEAD_BAND && r < DEAD_BAND) r = 0;
		return r;
	endfunction

	// advance the axis state by one accepted word and queue the expected result
	task automatic predict_axis_word(input raw_group_t grp, input logic ack);
		int v;
		axis_word_t w;
		if (ack) pending_m = 1'b0;
		if (!pending_m) begin
			v = conditioned_axis(grp);
			if (v == last_axis_m) begin
				changed_m = 1'b0;
			end else begin
				last_axis_m = v;
				changed_m = 1'b1;
				pending_m = 1'b1;
			end
		end
		w.axis = AXIS_W'(last_axis_m);
		w.changed = changed_m;
		w.ready = pending_m;
		expected_axis_q.push_back(w);
	endtask

	// one input word through the handshake
	task automatic send_word(input logic [RAW_W-1:0] a, b, c, d, e, input logic ack);
		int gap;
		raw_group_t grp;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		grp = {e, d, c, b, a};
		in_valid <= 1'b1;
		sample_a <= a;
		sample_b <= b;
		sample_c <= c;
		sample_d <= d;
		sample_e <= e;
		ack_consumed <= ack;
		do @(posedge clk); while (!in_ready);
		predict_axis_word(grp, ack);
		last_group = grp;
	endtask

	// stop sending and let every outstanding word come back
	task automatic drain_words();
		in_valid <= 1'b0;
		while (expected_axis_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write, mirrored into the model
	task automatic write_reg(input cfg_reg_t idx, input int value);
		logic [CFG_W-1:0] data;
		data = CFG_W'(value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_CENTER_TRIM: trim_m = int'($signed(data[TRIM_W-1:0]));
			REG_INVERT_AXIS: invert_m = data[0];
			REG_CLAMP_LOW:   low_m = int'($signed(data[AXIS_W-1:0]));
			REG_CLAMP_HIGH:  high_m = int'($signed(data[AXIS_W-1:0]));
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_registers(input int trim, input int inv, input int lo, input int hi);
		write_reg(REG_CENTER_TRIM, trim);
		write_reg(REG_INVERT_AXIS, inv);
		write_reg(REG_CLAMP_LOW, lo);
		write_reg(REG_CLAMP_HIGH, hi);
	endtask

	// pick a clamp limit: mostly in range, sometimes extreme or any 10-bit code
	function automatic int random_limit();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) begin
			case ($urandom_range(0, 4))
				0: return -256;
				1: return 256;
				2: return -512;
				3: return 511;
				default: return 0;
			endcase
		end
		if (r < 4) return $urandom_range(0, 1023) - 512;
		return $urandom_range(0, 512) - 256;
	endfunction

	// median selection and deadzone edges at reset settings
	task automatic test_median_and_deadzone();
		send_word(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0);
		send_word(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1);
		send_word(10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 1'b1);
		send_word(10'd515, 10'd515, 10'd513, 10'd514, 10'd515, 1'b1);
		send_word(10'd524, 10'd1023, 10'd0, 10'd524, 10'd527, 1'b1);
		send_word(10'd528, 10'd528, 10'd0, 10'd1023, 10'd531, 1'b1);
		send_word(10'd496, 10'd0, 10'd499, 10'd1023, 10'd496, 1'b1);
		send_word(10'd500, 10'd503, 10'd500, 10'd3, 10'd1020, 1'b1);
		send_word(10'd1023, 10'd0, 10'd600, 10'd3, 10'd1000, 1'b1);
		send_word(10'd400, 10'd400, 10'd100, 10'd900, 10'd400, 1'b1);
	endtask

	// pending latch holds state until acknowledged
	task automatic test_pending_and_ack();
		send_word(10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 1'b0);
		send_word(10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 1'b1);
		send_word(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0);
		send_word(10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 1'b1);
		send_word(10'h3FF, 10'h200, 10'h1FF, 10'h100, 10'h0FF, 1'b1);
	endtask

	// trim extremes, each with and without inversion
	task automatic test_trim_and_invert();
		drain_words();
		set_registers(-128, 0, -256, 256);
		send_word(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1);
		drain_words();
		write_reg(REG_INVERT_AXIS, 1);
		send_word(10'd3, 10'd2, 10'd1, 10'd0, 10'd3, 1'b1);
		drain_words();
		set_registers(127, 0, -256, 256);
		send_word(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1);
		drain_words();
		write_reg(REG_INVERT_AXIS, 1);
		send_word(10'd1020, 10'd1023, 10'd1021, 10'd1022, 10'd1023, 1'b1);
	endtask

	// crossed limits, equal limits and limits at the ends of the axis range
	task automatic test_clamp_limits();
		drain_words();
		set_registers(0, 0, 100, -100);
		send_word(10'd800, 10'd800, 10'd800, 10'd800, 10'd800, 1'b1);
		drain_words();
		set_registers(0, 0, 5, 5);
		send_word(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1);
		drain_words();
		set_registers(0, 0, 2, 3);
		send_word(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1);
		drain_words();
		set_registers(0, 1, -512, 511);
		send_word(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1);
		drain_words();
		set_registers(0, 0, 511, -512);
		send_word(10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 1'b1);
	endtask

	// random sample groups: clustered, repeated and noise, with random settings
	task automatic test_random_traffic();
		int phase;
		int n;
		int k;
		int mode;
		int center;
		int s;
		raw_group_t grp;
		logic ack;
		for (phase = 0; phase < 10; phase++) begin
			drain_words();
			case (phase)
				0: set_registers(0, 0, -256, 256);
				1: set_registers(-128, 1, -256, 256);
				2: set_registers(127, 0, random_limit(), random_limit());
				default: set_registers($urandom_range(0, 255) - 128, $urandom_range(0, 1),
					random_limit(), random_limit());
			endcase
			calm_mode = (phase == 4 || phase == 7);
			for (n = 0; n < 125; n++) begin
				mode = $urandom_range(0, 9);
				if (mode < 6) begin
					center = ($urandom_range(0, 1)) ? $urandom_range(472, 552) :
						$urandom_range(0, 1023);
					for (k = 0; k < FIELD_SAMPLES; k++) begin
						s = center + $urandom_range(0, 24) - 12;
						if (s < 0) s = 0;
						if (s > 1023) s = 1023;
						grp[k] = RAW_W'(s);
					end
					if ($urandom_range(0, 3) == 0) begin
						grp[$urandom_range(0, FIELD_SAMPLES - 1)] = RAW_W'($urandom_range(0, 1023));
					end
				end else if (mode < 8) begin
					grp = last_group;
				end else begin
					for (k = 0; k < FIELD_SAMPLES; k++) begin
						grp[k] = RAW_W'($urandom_range(0, 1023));
					end
				end
				ack = ($urandom_range(0, 9) < 7);
				send_word(grp[0], grp[1], grp[2], grp[3], grp[4], ack);
			end
		end
		calm_mode = 1'b0;
	endtask

	// result side back-pressure
	initial begin
		out_ready = 1'b0;
		rx_hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else begin
				out_ready <= 1'b1;
				if (!calm_mode && $urandom_range(0, 3) == 0) rx_hold = pick_gap();
			end
		end
	end

	// compare each result word with the oldest expected one
	always @(posedge clk) begin : check_words
		axis_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_axis_q.size() == 0) begin
				$error("result word with nothing expected: axis_value %0d", axis_value);
				errors++;
			end else begin
				want = expected_axis_q.pop_front();
				if (axis_value !== want.axis) begin
					$error("axis_value: expected %0d, got %0d", want.axis, axis_value);
					errors++;
				end
				if (value_changed !== want.changed) begin
					$error("value_changed: expected %0b, got %0b", want.changed, value_changed);
					errors++;
				end
				if (value_ready !== want.ready) begin
					$error("value_ready: expected %0b, got %0b", want.ready, value_ready);
					errors++;
				end
			end
		end
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample_a = '0;
		sample_b = '0;
		sample_c = '0;
		sample_d = '0;
		sample_e = '0;
		ack_consumed = 1'b0;
		errors = 0;
		calm_mode = 1'b0;
		trim_m = 0;
		invert_m = 1'b0;
		low_m = -256;
		high_m = 256;
		last_axis_m = -1;
		changed_m = 1'b0;
		pending_m = 1'b0;
		last_group = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_median_and_deadzone();
		test_pending_and_ack();
		test_trim_and_invert();
		test_clamp_limits();
		test_random_traffic();

		drain_words();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
